// ===== src/hdsu_pkg.sv =====
// ----------------------------------------------------------------------------
// hdsu_pkg
// Types and constants shared by the half-duplex soft UART modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hdsu_pkg;

	localparam int unsigned CFG_ADDR_W = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_BIT_TICKS   = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_START_DELAY = 1'd1;

	localparam logic [7:0] BIT_TICKS_RST   = 8'd24;
	localparam logic [7:0] START_DELAY_RST = 8'd12;

	typedef struct packed {
		logic       rx_pin;
		logic       send_req;
		logic [7:0] send_byte;
		logic       take_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_pin;
		logic       tx_ready;
		logic       byte_available;
		logic [7:0] rx_byte;
	} out_item_t;

	typedef struct packed {
		logic [7:0] bit_ticks;
		logic [7:0] start_delay_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/half_duplex_soft_uart_top.sv =====
// ----------------------------------------------------------------------------
// half_duplex_soft_uart_top
// 8N1 half-duplex UART advanced by one timer tick per input transfer.
//
//  channel | signals                       | direction | role
//  in      | in_valid, in_stall, in_data   | in        | one tick per transfer
//  out     | out_valid, out_stall, out_data| out       | one result per tick
//  cfg     | cfg_valid, cfg_ready, cfg_addr, cfg_data | in | register write
//
// One tick per clock while out_stall is low, via the input and result
// registers. The state machine steps when the input register moves into
// the result register. Reset clears valids, state and config to defaults.
// in_stall rises only while both registers hold items and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module half_duplex_soft_uart_top
	import hdsu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [7:0]            cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;
	cfg_t      cfg_q;
	out_item_t res;
	logic      out_free;
	logic      step;

	assign out_free  = !out_valid_q || !out_stall;
	assign step      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_ticks         <= BIT_TICKS_RST;
			cfg_q.start_delay_ticks <= START_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_addr == REG_BIT_TICKS) begin
				cfg_q.bit_ticks <= cfg_data;
			end
			if (cfg_addr == REG_START_DELAY) begin
				cfg_q.start_delay_ticks <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (step) begin
			out_data_q <= res;
		end
	end

	hdsu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_data_q)))
		else $error("stalled result lost or changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a full pipeline");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("step without a result");

endmodule

`default_nettype wire

// ===== src/hdsu_core.sv =====
// ----------------------------------------------------------------------------
// hdsu_core
// Tick-driven transmit/receive state machine; advances one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module hdsu_core
	import hdsu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	input  wire cfg_t      cfg,
	output out_item_t      res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_TX_START,
		PH_TX_BITS,
		PH_TX_LAST,
		PH_TX_STOP,
		PH_RX_DELAY,
		PH_RX_BITS,
		PH_RX_LAST,
		PH_RX_STOP
	} phase_t;

	phase_t     phase_q,    phase_d;
	logic [7:0] elapsed_q,  elapsed_d;
	logic [7:0] tx_shift_q, tx_shift_d;
	logic [2:0] tx_count_q, tx_count_d;
	logic [7:0] rx_shift_q, rx_shift_d;
	logic [2:0] rx_count_q, rx_count_d;
	logic       tx_pend_q,  tx_pend_d;
	logic       rx_flag_q,  rx_flag_d;
	logic       tx_level_q, tx_level_d;
	logic       bit_due;
	logic [7:0] rx_sampled;

	always_comb begin
		phase_d    = phase_q;
		elapsed_d  = (elapsed_q != 8'hFF) ? elapsed_q + 8'd1 : elapsed_q;
		tx_shift_d = tx_shift_q;
		tx_count_d = tx_count_q;
		rx_shift_d = rx_shift_q;
		rx_count_d = rx_count_q;
		tx_pend_d  = tx_pend_q;
		rx_flag_d  = rx_flag_q;
		tx_level_d = tx_level_q;

		if (item.send_req && !tx_pend_q) begin
			tx_pend_d  = 1'b1;
			tx_shift_d = item.send_byte;
		end
		if (item.take_byte) begin
			rx_flag_d = 1'b0;
		end

		bit_due    = elapsed_d >= cfg.bit_ticks;
		rx_sampled = {item.rx_pin, rx_shift_q[6:0]};

		case (phase_q)
			PH_IDLE: begin
				if (tx_pend_d) begin
					tx_level_d = 1'b0;
					elapsed_d  = '0;
					phase_d    = PH_TX_START;
				end else if (!item.rx_pin) begin
					rx_shift_d = '0;
					rx_count_d = '0;
					elapsed_d  = '0;
					phase_d    = PH_RX_DELAY;
				end
			end
			PH_TX_START: begin
				if (bit_due) begin
					tx_count_d = '0;
					tx_level_d = tx_shift_d[0];
					tx_shift_d = {1'b0, tx_shift_d[7:1]};
					elapsed_d  = '0;
					phase_d    = PH_TX_BITS;
				end
			end
			PH_TX_BITS: begin
				if (tx_count_q != 3'd7) begin
					if (bit_due) begin
						elapsed_d  = '0;
						tx_level_d = tx_shift_d[0];
						tx_shift_d = {1'b0, tx_shift_d[7:1]};
						tx_count_d = tx_count_q + 3'd1;
					end
				end else begin
					phase_d = PH_TX_LAST;
				end
			end
			PH_TX_LAST: begin
				if (bit_due) begin
					elapsed_d  = '0;
					tx_level_d = 1'b1;
					phase_d    = PH_TX_STOP;
				end
			end
			PH_TX_STOP: begin
				if (bit_due) begin
					tx_pend_d = 1'b0;
					phase_d   = PH_IDLE;
				end
			end
			PH_RX_DELAY: begin
				if (elapsed_d >= cfg.start_delay_ticks) begin
					elapsed_d = '0;
					phase_d   = PH_RX_BITS;
				end
			end
			PH_RX_BITS: begin
				if (rx_count_q != 3'd7) begin
					if (bit_due) begin
						elapsed_d  = '0;
						rx_shift_d = {1'b0, rx_sampled[7:1]};
						rx_count_d = rx_count_q + 3'd1;
					end
				end else begin
					phase_d = PH_RX_LAST;
				end
			end
			PH_RX_LAST: begin
				if (bit_due) begin
					elapsed_d  = '0;
					rx_shift_d = rx_sampled;
					phase_d    = PH_RX_STOP;
				end
			end
			PH_RX_STOP: begin
				if (bit_due) begin
					rx_flag_d = 1'b1;
					phase_d   = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		res.tx_pin         = tx_level_d;
		res.tx_ready       = !tx_pend_d;
		res.byte_available = rx_flag_q;
		res.rx_byte        = rx_shift_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			elapsed_q  <= '0;
			tx_shift_q <= '0;
			tx_count_q <= '0;
			rx_shift_q <= '0;
			rx_count_q <= '0;
			tx_pend_q  <= 1'b0;
			rx_flag_q  <= 1'b0;
			tx_level_q <= 1'b1;
		end else if (step) begin
			phase_q    <= phase_d;
			elapsed_q  <= elapsed_d;
			tx_shift_q <= tx_shift_d;
			tx_count_q <= tx_count_d;
			rx_shift_q <= rx_shift_d;
			rx_count_q <= rx_count_d;
			tx_pend_q  <= tx_pend_d;
			rx_flag_q  <= rx_flag_d;
			tx_level_q <= tx_level_d;
		end
	end

	// a frame in flight always has its send pending
	a_tx_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TX_START || phase_q == PH_TX_BITS ||
		 phase_q == PH_TX_LAST || phase_q == PH_TX_STOP) |-> tx_pend_q)
		else $error("transmit phase without pending send");

	a_start_bit_low: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TX_START) |-> !tx_level_q)
		else $error("start bit not driven low");

	a_rx_line_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RX_DELAY || phase_q == PH_RX_BITS ||
		 phase_q == PH_RX_LAST || phase_q == PH_RX_STOP) |-> tx_level_q)
		else $error("tx line not idle during reception");

	a_flag_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rx_flag_q) |-> $past(phase_q == PH_RX_STOP && step))
		else $error("byte flag raised outside stop phase");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the half-duplex soft UART. A queue of ticks and
// register writes, filled at time zero, feeds a clocked driver with random
// gaps. Framed RX bytes, random sends and flag reads run under several
// timings. Each accepted tick is run through a local UART model. A monitor
// with random stalls compares every result transfer with the oldest
// predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import hdsu_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 10;

	typedef enum logic [1:0] {CMD_TICK, CMD_CFG, CMD_DRAIN} stim_kind_e;

	typedef enum logic [3:0] {
		S_IDLE, S_TX_START, S_TX_BITS, S_TX_LAST, S_TX_STOP,
		S_RX_DELAY, S_RX_BITS, S_RX_LAST, S_RX_STOP
	} uart_phase_e;

	typedef struct {
		stim_kind_e              kind;
		in_item_t                item;
		int                      gap;
		logic [CFG_ADDR_W-1:0]   addr;
		logic [7:0]              data;
	} stim_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [7:0]            cfg_data  = '0;

	stim_t     stim_q[$];
	out_item_t uart_expect_q[$];

	int  stim_ticks = 0;
	int  err_cnt    = 0;
	int  result_cnt = 0;
	int  cycle_cnt  = 0;
	bit  tx_calm    = 1'b0;
	bit  rx_calm    = 1'b0;

	// UART model state
	logic [7:0]  bit_period = BIT_TICKS_RST;
	logic [7:0]  start_wait = START_DELAY_RST;
	uart_phase_e ph         = S_IDLE;
	logic [7:0]  tick_cnt   = '0;
	logic [7:0]  tx_sr      = '0;
	logic [2:0]  tx_bits    = '0;
	logic [7:0]  rx_sr      = '0;
	logic [2:0]  rx_bits    = '0;
	logic        tx_busy    = 1'b0;
	logic        rx_full    = 1'b0;
	logic        tx_line    = 1'b1;

	half_duplex_soft_uart_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
		if (idx == REG_BIT_TICKS)
			bit_period = val;
		else if (idx == REG_START_DELAY)
			start_wait = val;
	endfunction

	function automatic out_item_t uart_tick(in_item_t it);
		out_item_t res;
		logic      avail;
		logic      due;
		if (tick_cnt != 8'hFF)
			tick_cnt = tick_cnt + 8'd1;
		if (it.send_req && !tx_busy) begin
			tx_busy = 1'b1;
			tx_sr   = it.send_byte;
		end
		avail = rx_full;
		if (it.take_byte)
			rx_full = 1'b0;
		due = tick_cnt >= bit_period;
		case (ph)
			S_IDLE: begin
				if (tx_busy) begin
					tx_line  = 1'b0;
					tick_cnt = '0;
					ph       = S_TX_START;
				end else if (!it.rx_pin) begin
					rx_sr    = '0;
					rx_bits  = '0;
					tick_cnt = '0;
					ph       = S_RX_DELAY;
				end
			end
			S_TX_START: begin
				if (due) begin
					tx_bits  = '0;
					tx_line  = tx_sr[0];
					tx_sr    = tx_sr >> 1;
					tick_cnt = '0;
					ph       = S_TX_BITS;
				end
			end
			S_TX_BITS: begin
				if (tx_bits < 3'd7) begin
					if (due) begin
						tick_cnt = '0;
						tx_line  = tx_sr[0];
						tx_sr    = tx_sr >> 1;
						tx_bits  = tx_bits + 3'd1;
					end
				end else begin
					ph = S_TX_LAST;
				end
			end
			S_TX_LAST: begin
				if (due) begin
					tick_cnt = '0;
					tx_line  = 1'b1;
					ph       = S_TX_STOP;
				end
			end
			S_TX_STOP: begin
				if (due) begin
					tx_busy = 1'b0;
					ph      = S_IDLE;
				end
			end
			S_RX_DELAY: begin
				if (tick_cnt >= start_wait) begin
					tick_cnt = '0;
					ph       = S_RX_BITS;
				end
			end
			S_RX_BITS: begin
				if (rx_bits < 3'd7) begin
					if (due) begin
						tick_cnt = '0;
						rx_sr    = {it.rx_pin, rx_sr[6:0]} >> 1;
						rx_bits  = rx_bits + 3'd1;
					end
				end else begin
					ph = S_RX_LAST;
				end
			end
			S_RX_LAST: begin
				if (due) begin
					tick_cnt = '0;
					rx_sr    = {it.rx_pin, rx_sr[6:0]};
					ph       = S_RX_STOP;
				end
			end
			S_RX_STOP: begin
				if (due) begin
					rx_full = 1'b1;
					ph      = S_IDLE;
				end
			end
			default: ph = S_IDLE;
		endcase
		res.tx_pin         = tx_line;
		res.tx_ready       = !tx_busy;
		res.byte_available = avail;
		res.rx_byte        = rx_sr;
		return res;
	endfunction

	task automatic push_tick(input logic rx, input logic req, input logic [7:0] val,
			input logic take);
		stim_t s;
		s.kind           = CMD_TICK;
		s.item.rx_pin    = rx;
		s.item.send_req  = req;
		s.item.send_byte = val;
		s.item.take_byte = take;
		s.gap            = tx_calm ? 0 : $urandom_range(0, 10);
		s.addr           = '0;
		s.data           = '0;
		stim_q.push_back(s);
		stim_ticks++;
	endtask

	task automatic push_rand_tick(input logic rx);
		push_tick(rx, $urandom_range(0, 23) == 0, 8'($urandom), $urandom_range(0, 3) == 0);
	endtask

	task automatic push_cmd(input stim_kind_e kind, input logic [CFG_ADDR_W-1:0] idx,
			input logic [7:0] val);
		stim_t s;
		s.kind = kind;
		s.item = '0;
		s.gap  = 0;
		s.addr = idx;
		s.data = val;
		stim_q.push_back(s);
	endtask

	// one 8N1 frame on the RX line, with occasional bit-time jitter and bad stop bits
	task automatic push_frame(input int bt);
		logic [7:0] val;
		logic       level;
		int         hold;
		int         k;
		val = 8'($urandom);
		repeat ($urandom_range(0, 2 * bt)) push_rand_tick(1'b1);
		for (k = 0; k < 10; k++) begin
			if (k == 0)
				level = 1'b0;
			else if (k == 9)
				level = $urandom_range(0, 7) != 0;
			else
				level = val[k-1];
			hold = bt;
			if ($urandom_range(0, 7) == 0)
				hold = bt + int'($urandom_range(0, 2)) - 1;
			if (hold < 1)
				hold = 1;
			repeat (hold) push_rand_tick(level);
		end
	endtask

	task automatic run_phase(input logic [7:0] bt, input logic [7:0] sd, input int n);
		int stop_at;
		push_cmd(CMD_CFG, REG_BIT_TICKS, bt);
		push_cmd(CMD_CFG, REG_START_DELAY, sd);
		tx_calm = $urandom_range(0, 2) == 0;
		stop_at = stim_ticks + n;
		while (stim_ticks < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				tx_calm = !tx_calm;
			if ($urandom_range(0, 40) == 0)
				push_cmd(CMD_DRAIN, '0, '0);
			if (bt <= 8 && $urandom_range(0, 9) < 8)
				push_frame(int'(bt));
			else
				repeat ($urandom_range(1, 8)) push_rand_tick(1'($urandom_range(0, 1)));
		end
	endtask

	task automatic fill_stimulus();
		int k;
		repeat (20) push_rand_tick(1'($urandom_range(0, 1)));
		push_cmd(CMD_CFG, REG_BIT_TICKS, 8'd1);
		push_cmd(CMD_CFG, REG_START_DELAY, 8'd1);
		// send all ones, then a send while busy, rx low while transmitting
		push_tick(1'b1, 1'b1, 8'hFF, 1'b0);
		push_tick(1'b0, 1'b1, 8'h00, 1'b1);
		repeat (10) push_tick(1'b1, 1'b0, 8'h00, 1'b0);
		// reception, send accepted mid-reception, flag reads
		push_tick(1'b0, 1'b0, 8'h00, 1'b0);
		push_tick(1'b0, 1'b1, 8'h00, 1'b0);
		for (k = 0; k < 8; k++)
			push_tick(k[0], 1'b0, 8'h00, 1'b0);
		push_tick(1'b0, 1'b0, 8'h00, 1'b0);
		push_tick(1'b1, 1'b0, 8'h00, 1'b1);
		push_tick(1'b1, 1'b0, 8'h00, 1'b1);
		push_cmd(CMD_DRAIN, '0, '0);
		run_phase(8'd1, 8'd1, 150);
		run_phase(8'd2, 8'd1, 150);
		run_phase(8'd3, 8'd2, 150);
		run_phase(8'd1, 8'd255, 80);
		run_phase(8'd255, 8'd1, 60);
		run_phase(8'd255, 8'd255, 40);
		run_phase(BIT_TICKS_RST, START_DELAY_RST, 60);
		repeat (3) run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)), 150);
		run_phase(8'd4, 8'd3, 150);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		stim_t s;
		logic  nxt_in_valid;
		logic  nxt_cfg_valid;
		int    gap_cnt;
		int    settle_cnt;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			cfg_valid  <= 1'b0;
			gap_cnt    = 0;
			settle_cnt = 0;
		end else begin
			nxt_in_valid  = in_valid;
			nxt_cfg_valid = cfg_valid;
			if (in_valid && !in_stall) begin
				uart_expect_q.push_back(uart_tick(in_data));
				nxt_in_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				write_reg(cfg_addr, cfg_data);
				nxt_cfg_valid = 1'b0;
			end
			if (uart_expect_q.size() == 0 && !nxt_in_valid && !nxt_cfg_valid)
				settle_cnt = (settle_cnt < SETTLE_CYCLES) ? settle_cnt + 1 : settle_cnt;
			else
				settle_cnt = 0;
			if (!nxt_in_valid && !nxt_cfg_valid && stim_q.size() != 0) begin
				s = stim_q[0];
				case (s.kind)
					CMD_TICK: begin
						if (gap_cnt < s.gap) begin
							gap_cnt++;
						end else begin
							gap_cnt = 0;
							in_data      <= s.item;
							nxt_in_valid = 1'b1;
							stim_q.delete(0);
						end
					end
					CMD_CFG: begin
						if (settle_cnt >= SETTLE_CYCLES) begin
							cfg_addr      <= s.addr;
							cfg_data      <= s.data;
							nxt_cfg_valid = 1'b1;
							settle_cnt    = 0;
							stim_q.delete(0);
						end
					end
					default: begin
						if (settle_cnt >= SETTLE_CYCLES)
							stim_q.delete(0);
					end
				endcase
			end
			in_valid  <= nxt_in_valid;
			cfg_valid <= nxt_cfg_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_proc
		out_item_t want;
		int        hold_cnt;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_cnt++;
				if (uart_expect_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result transfer %0d with nothing expected: %h",
							$realtime, result_cnt, out_data);
				end else begin
					want = uart_expect_q.pop_front();
					if (out_data.tx_pin !== want.tx_pin ||
							out_data.tx_ready !== want.tx_ready ||
							out_data.byte_available !== want.byte_available ||
							out_data.rx_byte !== want.rx_byte) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$write("%0t: result %0d exp/act tx_pin %b/%b tx_ready %b/%b",
								$realtime, result_cnt,
								want.tx_pin, out_data.tx_pin,
								want.tx_ready, out_data.tx_ready);
							$display(" byte_available %b/%b rx_byte %h/%h",
								want.byte_available, out_data.byte_available,
								want.rx_byte, out_data.rx_byte);
						end
					end
				end
				if (result_cnt % 150 == 0)
					rx_calm = $urandom_range(0, 2) == 0;
				hold_cnt = rx_calm ? 0 : int'($urandom_range(0, 10));
			end
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		fill_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || in_valid || cfg_valid || uart_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
